### hdl/pial_pkg.sv
`default_nettype none

package pial_pkg;

  // list storage geometry
  localparam int unsigned Depth    = 128;
  localparam int unsigned Capacity = (Depth < 255) ? Depth : 255;
  localparam int unsigned AddrW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW     = 8;
  localparam int unsigned DataW    = 32;

  // request operation codes
  typedef enum logic [1:0] {
    OpInsert = 2'd0,
    OpDelete = 2'd1,
    OpFind   = 2'd2,
    OpRead   = 2'd3
  } op_e;

  // result status codes
  typedef enum logic [1:0] {
    StatOk       = 2'd0,
    StatFull     = 2'd1,
    StatBadPos   = 2'd2,
    StatNotFound = 2'd3
  } status_e;

  // sequencer states
  typedef enum logic [3:0] {
    StIdle,
    StInsRd,
    StInsWr,
    StInsVal,
    StDelRd,
    StDelWr,
    StFindRd,
    StFindChk,
    StRdRd,
    StRdChk,
    StDone
  } state_e;

endpackage

`default_nettype wire

### hdl/position_indexed_array_list.sv
// Ordered list of signed 32-bit values held in a single-port RAM plus a length
// register. One request beat on the input channel (func_i, position_i,
// item_value_i) gives exactly one result beat on the output channel (status_o,
// found_position_o, read_value_o, list_length_o). Both channels use
// valid/ready; a beat moves when valid and ready are high at a rising edge.
// The block works on one request at a time. Each entry move or compare takes
// a read of the single RAM port, then a write or a check, so the time for a
// request grows with the list length and the position. Insert shifts entries
// from the list end down to the position up by one, then writes the value;
// delete shifts the entries above the position down by one; find compares
// entries from the first until one matches; read fetches one entry; rejected
// requests go straight to the result.
// Results go into an output register, so a new request is taken while the
// previous result still waits; if the receiver stalls, the next finished
// result holds in the sequencer until the output register frees.
// rst_ni (async, active low) empties the list; RAM contents are left as they
// are and are never used before being written.
`default_nettype none

module position_indexed_array_list
  import pial_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic [1:0]              func_i,
  input  wire logic [7:0]              position_i,
  input  wire logic signed [DataW-1:0] item_value_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic [1:0]                   status_o,
  output logic [7:0]                   found_position_o,
  output logic signed [DataW-1:0]      read_value_o,
  output logic [7:0]                   list_length_o
);

  // list memory
  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rdata_q;
  logic [AddrW-1:0] mem_addr;
  logic [DataW-1:0] mem_wdata;
  logic             mem_we;

  state_e            state_q, state_d;
  logic [CntW-1:0]   pos_q, pos_d;
  logic [DataW-1:0]  val_q, val_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CntW-1:0]   idx_q, idx_d;
  status_e           stat_q, stat_d;
  logic [CntW-1:0]   found_q, found_d;
  logic [DataW-1:0]  rd_q, rd_d;

  logic              out_valid_q, out_valid_d;
  status_e           out_stat_q, out_stat_d;
  logic [CntW-1:0]   out_found_q, out_found_d;
  logic [DataW-1:0]  out_rd_q, out_rd_d;
  logic [CntW-1:0]   out_len_q, out_len_d;

  logic              in_fire;
  logic              out_free;
  logic              ins_full;
  logic              ins_bad;
  logic              pos_bad;
  logic              ins_more;
  logic              del_more;
  logic              find_more;
  logic              hit;
  logic [CntW:0]     cnt_inc;
  logic [CntW:0]     idx_inc;

  // shared conditions
  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign cnt_inc    = {1'b0, cnt_q} + {{CntW{1'b0}}, 1'b1};
  assign idx_inc    = {1'b0, idx_q} + {{CntW{1'b0}}, 1'b1};
  assign ins_full   = ({1'b0, cnt_q} >= (CntW + 1)'(Capacity));
  assign ins_bad    = (position_i == '0) || ({1'b0, position_i} > cnt_inc);
  assign pos_bad    = (position_i == '0) || (position_i > cnt_q);
  assign ins_more   = (idx_q >= pos_q);
  assign del_more   = (idx_inc < {1'b0, cnt_q});
  assign find_more  = (idx_q < cnt_q);
  assign hit        = (rdata_q == val_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          unique case (op_e'(func_i))
            OpInsert: state_d = (ins_full || ins_bad) ? StDone : StInsRd;
            OpDelete: state_d = pos_bad ? StDone : StDelRd;
            OpFind:   state_d = StFindRd;
            OpRead:   state_d = pos_bad ? StDone : StRdRd;
            default:  state_d = StDone;
          endcase
        end
      end
      StInsRd:   state_d = ins_more ? StInsWr : StInsVal;
      StInsWr:   state_d = StInsRd;
      StInsVal:  state_d = StDone;
      StDelRd:   state_d = del_more ? StDelWr : StDone;
      StDelWr:   state_d = StDelRd;
      StFindRd:  state_d = find_more ? StFindChk : StDone;
      StFindChk: state_d = hit ? StDone : StFindRd;
      StRdRd:    state_d = StRdChk;
      StRdChk:   state_d = StDone;
      StDone:    state_d = out_free ? StIdle : StDone;
      default:   state_d = StIdle;
    endcase
  end

  // datapath, memory port and output register control
  always_comb begin
    pos_d       = pos_q;
    val_d       = val_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    stat_d      = stat_q;
    found_d     = found_q;
    rd_d        = rd_q;
    mem_addr    = AddrW'(idx_q);
    mem_wdata   = rdata_q;
    mem_we      = 1'b0;
    out_valid_d = out_valid_q;
    out_stat_d  = out_stat_q;
    out_found_d = out_found_q;
    out_rd_d    = out_rd_q;
    out_len_d   = out_len_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          pos_d   = position_i;
          val_d   = item_value_i;
          found_d = '0;
          rd_d    = '0;
          stat_d  = StatOk;
          idx_d   = position_i - CntW'(1);
          unique case (op_e'(func_i))
            OpInsert: begin
              idx_d = cnt_q;
              if (ins_full) begin
                stat_d = StatFull;
              end else if (ins_bad) begin
                stat_d = StatBadPos;
              end
            end
            OpDelete, OpRead: begin
              if (pos_bad) begin
                stat_d = StatBadPos;
              end
            end
            OpFind: begin
              idx_d  = '0;
              stat_d = StatNotFound;
            end
            default: stat_d = StatBadPos;
          endcase
        end
      end
      // shift up: read entry below, then write it one higher
      StInsRd: begin
        mem_addr = AddrW'(idx_q - CntW'(1));
      end
      StInsWr: begin
        mem_we = 1'b1;
        idx_d  = idx_q - CntW'(1);
      end
      StInsVal: begin
        mem_we    = 1'b1;
        mem_wdata = val_q;
        cnt_d     = cnt_q + CntW'(1);
      end
      // shift down: read entry above, then write it one lower
      StDelRd: begin
        mem_addr = AddrW'(idx_inc);
        if (!del_more) begin
          cnt_d = cnt_q - CntW'(1);
        end
      end
      StDelWr: begin
        mem_we = 1'b1;
        idx_d  = idx_inc[CntW-1:0];
      end
      StFindRd: ;
      StFindChk: begin
        if (hit) begin
          stat_d  = StatOk;
          found_d = idx_inc[CntW-1:0];
        end else begin
          idx_d = idx_inc[CntW-1:0];
        end
      end
      StRdRd: ;
      StRdChk: begin
        rd_d = rdata_q;
      end
      StDone: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_stat_d  = stat_q;
          out_found_d = found_q;
          out_rd_d    = rd_q;
          out_len_d   = cnt_q;
        end
      end
      default: ;
    endcase
  end

  // single-port ram, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata_q <= mem[mem_addr];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pos_q       <= pos_d;
    val_q       <= val_d;
    idx_q       <= idx_d;
    stat_q      <= stat_d;
    found_q     <= found_d;
    rd_q        <= rd_d;
    out_stat_q  <= out_stat_d;
    out_found_q <= out_found_d;
    out_rd_q    <= out_rd_d;
    out_len_q   <= out_len_d;
  end

  // result beat
  assign out_valid_o      = out_valid_q;
  assign status_o         = out_stat_q;
  assign found_position_o = out_found_q;
  assign read_value_o     = out_rd_q;
  assign list_length_o    = out_len_q;

  // checks
  a_cnt_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Capacity))
    else $error("list length above capacity");

  a_wr_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (idx_q <= cnt_q))
    else $error("ram write beyond list end");

  a_found_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && found_position_o != '0) |-> (status_o == StatOk))
    else $error("found position with failing status");

  a_rd_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != StatOk) |-> (read_value_o == '0))
    else $error("read value on failed request");

  a_len_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |=> (cnt_q == $past(cnt_q)))
    else $error("length changed on accept");

endmodule

`default_nettype wire
